[rtl/core/slt_pkg.sv]
// Shared types and constants for the sequential list table.
// Used by slt_ctrl, slt_dpath and sequential_list_table; depends on nothing.
`default_nettype none

package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths on the streams
  localparam int FUNC_W   = 3;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;
  localparam int OIDX_W   = 4;
  localparam int OCNT_W   = 5;
  localparam int IN_W     = 40;  // key + position, padded to bytes
  localparam int OUT_W    = 16;  // status + index + count, padded to bytes

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DEL_CHK,
    S_DEL_WR,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_INS_WR,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RA_PTR,
    RA_PTR_M1,
    RA_PTR_P1
  } rd_addr_sel_t;

  typedef enum logic [1:0] {
    WA_PTR,
    WA_POS,
    WA_COUNT
  } wr_addr_sel_t;

  typedef enum logic {
    WD_KEY,
    WD_RD
  } wr_data_sel_t;

  typedef enum logic [1:0] {
    IX_ZERO,
    IX_POS,
    IX_PTR,
    IX_COUNT
  } idx_sel_t;

  // Controller -> datapath
  typedef struct packed {
    logic         load;
    logic         ptr_set_count;
    logic         ptr_inc;
    logic         ptr_dec;
    logic         rd_en;
    rd_addr_sel_t rd_addr_sel;
    logic         wr_en;
    wr_addr_sel_t wr_addr_sel;
    wr_data_sel_t wr_data_sel;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         cnt_clr;
    logic         res_set;
    status_t      res_status;
    idx_sel_t     res_idx_sel;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              pos_gt_count;
    logic              count_zero;
    logic              ptr_eq_pos;
    logic              ptr_last;
    logic              match;
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/slt_dpath.sv]
// Datapath of the sequential list table: key store, entry count, walk pointer
// and result registers. Depends on slt_pkg.
`default_nettype none

module slt_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire slt_pkg::cmd_t              cmd,
  output slt_pkg::stat_t                  stat,
  input  wire logic [slt_pkg::FUNC_W-1:0] in_func,
  input  wire logic [slt_pkg::KEY_W-1:0]  in_key,
  input  wire logic [slt_pkg::POS_W-1:0]  in_pos,
  output logic      [slt_pkg::STAT_W-1:0] out_status,
  output logic      [slt_pkg::OIDX_W-1:0] out_index,
  output logic      [slt_pkg::OCNT_W-1:0] out_count
);

  logic [slt_pkg::KEY_W-1:0]  mem [slt_pkg::CAPACITY];
  logic [slt_pkg::KEY_W-1:0]  rd_data;
  logic [slt_pkg::FUNC_W-1:0] func_r;
  logic [slt_pkg::KEY_W-1:0]  key_r;
  logic [slt_pkg::POS_W-1:0]  pos_r;
  logic [slt_pkg::IDX_W-1:0]  ptr;
  logic [slt_pkg::CNT_W-1:0]  count;
  slt_pkg::status_t           res_status;
  logic [slt_pkg::OIDX_W-1:0] res_index;

  logic [slt_pkg::IDX_W-1:0]  raddr;
  logic [slt_pkg::IDX_W-1:0]  waddr;
  logic [slt_pkg::KEY_W-1:0]  wdata;
  logic [slt_pkg::OIDX_W-1:0] idx_mux;

  always_comb begin
    case (cmd.rd_addr_sel)
      slt_pkg::RA_PTR_M1: raddr = ptr - slt_pkg::IDX_W'(1);
      slt_pkg::RA_PTR_P1: raddr = ptr + slt_pkg::IDX_W'(1);
      default:            raddr = ptr;
    endcase
    case (cmd.wr_addr_sel)
      slt_pkg::WA_POS:   waddr = slt_pkg::IDX_W'(pos_r);
      slt_pkg::WA_COUNT: waddr = slt_pkg::IDX_W'(count);
      default:           waddr = ptr;
    endcase
    wdata = (cmd.wr_data_sel == slt_pkg::WD_RD) ? rd_data : key_r;
    case (cmd.res_idx_sel)
      slt_pkg::IX_POS:   idx_mux = slt_pkg::OIDX_W'(pos_r);
      slt_pkg::IX_PTR:   idx_mux = slt_pkg::OIDX_W'(ptr);
      slt_pkg::IX_COUNT: idx_mux = slt_pkg::OIDX_W'(count);
      default:           idx_mux = '0;
    endcase
  end

  // Key store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_key;
      pos_r  <= in_pos;
    end
    if (cmd.load) begin
      ptr <= '0;
    end else if (cmd.ptr_set_count) begin
      ptr <= slt_pkg::IDX_W'(count);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + slt_pkg::IDX_W'(1);
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - slt_pkg::IDX_W'(1);
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_index  <= idx_mux;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + slt_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - slt_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    stat.func         = func_r;
    stat.full         = (32'(count) >= slt_pkg::CAPACITY);
    stat.pos_gt_count = (32'(pos_r) > 32'(count));
    stat.count_zero   = (count == '0);
    stat.ptr_eq_pos   = (32'(ptr) == 32'(pos_r));
    stat.ptr_last     = ((32'(ptr) + 32'd1) >= 32'(count));
    stat.match        = (rd_data == key_r);
  end

  assign out_status = res_status;
  assign out_index  = res_index;
  assign out_count  = slt_pkg::OCNT_W'(count);

endmodule

`default_nettype wire

[rtl/core/slt_ctrl.sv]
// Controller of the sequential list table: sequences search, shift and write
// steps and the stream handshakes. Depends on slt_pkg.
`default_nettype none

module slt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire slt_pkg::stat_t stat,
  output slt_pkg::cmd_t       cmd
);

  slt_pkg::state_t state;
  slt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.rd_addr_sel = slt_pkg::RA_PTR;
    cmd.wr_addr_sel = slt_pkg::WA_PTR;
    cmd.wr_data_sel = slt_pkg::WD_KEY;
    cmd.res_status  = slt_pkg::ST_OK;
    cmd.res_idx_sel = slt_pkg::IX_ZERO;
    in_ready        = 1'b0;
    out_valid       = 1'b0;

    case (state)
      slt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = slt_pkg::S_DECIDE;
        end
      end

      slt_pkg::S_DECIDE: begin
        state_next  = slt_pkg::S_RESP;
        cmd.res_set = 1'b1;
        case (stat.func)
          slt_pkg::FN_INSERT: begin
            if (stat.full) begin
              cmd.res_status = slt_pkg::ST_FULL;
            end else if (stat.pos_gt_count) begin
              cmd.res_status = slt_pkg::ST_RANGE;
            end else begin
              cmd.res_set       = 1'b0;
              cmd.ptr_set_count = 1'b1;
              state_next        = slt_pkg::S_SHIFT_CHK;
            end
          end
          slt_pkg::FN_APPEND: begin
            if (stat.full) begin
              cmd.res_status = slt_pkg::ST_FULL;
            end else begin
              cmd.wr_en       = 1'b1;
              cmd.wr_addr_sel = slt_pkg::WA_COUNT;
              cmd.res_idx_sel = slt_pkg::IX_COUNT;
              cmd.cnt_inc     = 1'b1;
            end
          end
          slt_pkg::FN_DELETE, slt_pkg::FN_SEARCH: begin
            if (stat.count_zero) begin
              cmd.res_status = slt_pkg::ST_MISSING;
            end else begin
              cmd.res_set = 1'b0;
              state_next  = slt_pkg::S_SRCH_RD;
            end
          end
          slt_pkg::FN_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: ;
        endcase
      end

      slt_pkg::S_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = slt_pkg::S_SRCH_CMP;
      end

      slt_pkg::S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.res_set     = 1'b1;
          cmd.res_idx_sel = slt_pkg::IX_PTR;
          state_next = (stat.func == slt_pkg::FN_DELETE) ? slt_pkg::S_DEL_CHK
                                                         : slt_pkg::S_RESP;
        end else if (stat.ptr_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = slt_pkg::ST_MISSING;
          state_next     = slt_pkg::S_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = slt_pkg::S_SRCH_RD;
        end
      end

      slt_pkg::S_DEL_CHK: begin
        if (stat.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = slt_pkg::S_RESP;
        end else begin
          cmd.rd_en       = 1'b1;
          cmd.rd_addr_sel = slt_pkg::RA_PTR_P1;
          state_next      = slt_pkg::S_DEL_WR;
        end
      end

      slt_pkg::S_DEL_WR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_data_sel = slt_pkg::WD_RD;
        cmd.ptr_inc     = 1'b1;
        state_next      = slt_pkg::S_DEL_CHK;
      end

      slt_pkg::S_SHIFT_CHK: begin
        if (stat.ptr_eq_pos) begin
          state_next = slt_pkg::S_INS_WR;
        end else begin
          cmd.rd_en       = 1'b1;
          cmd.rd_addr_sel = slt_pkg::RA_PTR_M1;
          state_next      = slt_pkg::S_SHIFT_WR;
        end
      end

      slt_pkg::S_SHIFT_WR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_data_sel = slt_pkg::WD_RD;
        cmd.ptr_dec     = 1'b1;
        state_next      = slt_pkg::S_SHIFT_CHK;
      end

      slt_pkg::S_INS_WR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = slt_pkg::WA_POS;
        cmd.cnt_inc     = 1'b1;
        cmd.res_set     = 1'b1;
        cmd.res_idx_sel = slt_pkg::IX_POS;
        state_next      = slt_pkg::S_RESP;
      end

      slt_pkg::S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = slt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = slt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/sequential_list_table.sv]
// Sequential list table top level: ordered list of signed 32-bit keys, one at a time.
// Clear, append, unused codes and errors go straight to the result; search, delete and
// insert walk the key store, since every entry visited costs a registered key store
// read, then a compare or a write-back. One request at a time: the next request is
// accepted from the cycle after the result is taken.
// Reset: synchronous, active high; empties the list; keys are undefined.
`default_nettype none

module sequential_list_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Request stream
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [slt_pkg::IN_W-1:0]  s_tdata,   // key[31:0], position[36:32], zero pad
  input  wire logic [slt_pkg::FUNC_W-1:0] s_tuser,  // func[2:0]
  // Result stream
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic      [slt_pkg::OUT_W-1:0] m_tdata    // status[1:0], index[5:2], count[10:6], zero pad
);

  slt_pkg::cmd_t  cmd;
  slt_pkg::stat_t stat;

  logic [slt_pkg::STAT_W-1:0] out_status;
  logic [slt_pkg::OIDX_W-1:0] out_index;
  logic [slt_pkg::OCNT_W-1:0] out_count;

  // Controller: accepts a request only when idle, holds the result until taken.
  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: captures the request, walks the key store, holds the result.
  slt_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (s_tuser),
    .in_key     (s_tdata[slt_pkg::KEY_W-1:0]),
    .in_pos     (s_tdata[slt_pkg::KEY_W +: slt_pkg::POS_W]),
    .out_status (out_status),
    .out_index  (out_index),
    .out_count  (out_count)
  );

  // Result packing, lowest field first; count reflects the list after the op.
  assign m_tdata = {5'd0, out_count, out_index, out_status};

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for sequential_list_table: directed table, then random traffic.
// Depends on slt_pkg and the sequential_list_table RTL; expected results come from
// a list predictor kept alongside the DUT.
`default_nettype none

module testbench;
  import slt_pkg::*;

  // Spare operation codes: the DUT must pass them through as no-ops
  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

  localparam int ITEMS_PER_PHASE = 153;
  localparam int N_PHASES        = 4;
  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 8;  // worst-case walk plus margin
  localparam int STALL_LIMIT     = 2000;              // cycles with no transaction at all

  typedef struct packed {
    status_t           status;
    logic [OIDX_W-1:0] index;
    logic [OCNT_W-1:0] count;
  } list_result_t;

  // One row of the directed table; reps > 1 repeats the row with key+i
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos;
    logic [4:0]        reps;
    logic              typed;
    list_result_t      want;
  } dir_row_t;

  localparam list_result_t NO_TYPED = '{ST_OK, 4'd0, 5'd0};
  localparam int N_DIRECTED = 25;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // empty list: search / delete miss, insert past the end
    '{FN_SEARCH, 32'h0000_0000, 5'd0,  5'd1,  1'b1, '{ST_MISSING, 4'd0, 5'd0}},
    '{FN_DELETE, 32'h0000_0000, 5'd0,  5'd1,  1'b1, '{ST_MISSING, 4'd0, 5'd0}},
    '{FN_INSERT, 32'h0000_0001, 5'd1,  5'd1,  1'b1, '{ST_RANGE,   4'd0, 5'd0}},
    // key extremes, insert in the middle, position field all ones
    '{FN_INSERT, 32'h8000_0000, 5'd0,  5'd1,  1'b1, '{ST_OK,      4'd0, 5'd1}},
    '{FN_APPEND, 32'h7FFF_FFFF, 5'd0,  5'd1,  1'b1, '{ST_OK,      4'd1, 5'd2}},
    '{FN_INSERT, 32'hFFFF_FFFF, 5'd1,  5'd1,  1'b0, NO_TYPED},
    '{FN_INSERT, 32'h0000_0000, 5'd31, 5'd1,  1'b1, '{ST_RANGE,   4'd0, 5'd3}},
    // duplicate key: search and delete hit the lowest index
    '{FN_APPEND, 32'h8000_0000, 5'd0,  5'd1,  1'b0, NO_TYPED},
    '{FN_SEARCH, 32'h8000_0000, 5'd0,  5'd1,  1'b1, '{ST_OK,      4'd0, 5'd4}},
    '{FN_DELETE, 32'h8000_0000, 5'd0,  5'd1,  1'b1, '{ST_OK,      4'd0, 5'd3}},
    '{FN_SEARCH, 32'h8000_0000, 5'd0,  5'd1,  1'b0, NO_TYPED},
    '{FN_SEARCH, 32'h1234_5678, 5'd0,  5'd1,  1'b1, '{ST_MISSING, 4'd0, 5'd3}},
    // unused codes are no-ops
    '{FN_SPARE_FIRST, 32'hFFFF_FFFF, 5'd31, 5'd1, 1'b1, '{ST_OK,  4'd0, 5'd3}},
    '{FN_SPARE_LAST,  32'h0000_0000, 5'd0,  5'd1, 1'b0, NO_TYPED},
    '{FN_CLEAR,  32'h0000_0000, 5'd0,  5'd1,  1'b1, '{ST_OK,      4'd0, 5'd0}},
    // fill to capacity, then every full-list case (full wins over range)
    '{FN_APPEND, 32'h1000_0000, 5'd0,  5'd16, 1'b0, NO_TYPED},
    '{FN_INSERT, 32'h0000_0000, 5'd0,  5'd1,  1'b1, '{ST_FULL,    4'd0, 5'd16}},
    '{FN_INSERT, 32'h0000_0000, 5'd31, 5'd1,  1'b1, '{ST_FULL,    4'd0, 5'd16}},
    '{FN_APPEND, 32'h0000_0000, 5'd0,  5'd1,  1'b1, '{ST_FULL,    4'd0, 5'd16}},
    // delete first (longest shift) and last (no shift)
    '{FN_DELETE, 32'h1000_0000, 5'd0,  5'd1,  1'b1, '{ST_OK,      4'd0, 5'd15}},
    '{FN_DELETE, 32'h1000_000F, 5'd0,  5'd1,  1'b0, NO_TYPED},
    // insert at position == count lands at the end
    '{FN_INSERT, 32'h5A5A_5A5A, 5'd14, 5'd1,  1'b0, NO_TYPED},
    '{FN_INSERT, 32'hA5A5_A5A5, 5'd16, 5'd1,  1'b1, '{ST_RANGE,   4'd0, 5'd15}},
    '{FN_INSERT, 32'hA5A5_A5A5, 5'd15, 5'd1,  1'b1, '{ST_OK,      4'd15, 5'd16}},
    '{FN_CLEAR,  32'h0000_0000, 5'd0,  5'd1,  1'b1, '{ST_OK,      4'd0, 5'd0}}
  };

  // DUT connections; every input starts at a known value
  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;   // key[31:0], position[36:32], zero pad
  logic [FUNC_W-1:0] s_tuser  = '0;   // func[2:0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;         // status[1:0], index[5:2], count[10:6], zero pad

  // Predictor state: a mirror of the list contents and length
  logic [KEY_W-1:0] list_keys [CAPACITY];
  int               list_len = 0;

  list_result_t pending_results [$];
  int           mismatches     = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles   = 0;

  sequential_list_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the mirrored list and return the result it should give
  function automatic list_result_t list_apply(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] key,
                                              logic [POS_W-1:0] pos);
    list_result_t r;
    int           hit;
    int           j;
    r.status = ST_OK;
    r.index  = '0;
    hit      = -1;
    if (op == FN_DELETE || op == FN_SEARCH) begin
      for (j = list_len - 1; j >= 0; j--) begin
        if (list_keys[j] == key) hit = j;
      end
    end
    case (op)
      FN_INSERT: begin
        if (list_len >= CAPACITY) r.status = ST_FULL;
        else if (int'(pos) > list_len) r.status = ST_RANGE;
        else begin
          for (j = list_len; j > int'(pos); j--) list_keys[j] = list_keys[j-1];
          list_keys[pos] = key;
          list_len++;
          r.index = pos[OIDX_W-1:0];
        end
      end
      FN_APPEND: begin
        if (list_len >= CAPACITY) r.status = ST_FULL;
        else begin
          list_keys[list_len] = key;
          r.index = OIDX_W'(list_len);
          list_len++;
        end
      end
      FN_DELETE: begin
        if (hit < 0) r.status = ST_MISSING;
        else begin
          r.index = OIDX_W'(hit);
          for (j = hit; j + 1 < list_len; j++) list_keys[j] = list_keys[j+1];
          list_len--;
        end
      end
      FN_SEARCH: begin
        if (hit < 0) r.status = ST_MISSING;
        else r.index = OIDX_W'(hit);
      end
      FN_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = OCNT_W'(list_len);
    return r;
  endfunction

  // Random request biased toward keys already in the list and legal positions
  task automatic pick_random_req(output logic [FUNC_W-1:0] op, output logic [KEY_W-1:0] key,
                                 output logic [POS_W-1:0] pos);
    int roll;
    roll = $urandom_range(99);
    if (roll < 24) op = FN_INSERT;
    else if (roll < 42) op = FN_APPEND;
    else if (roll < 68) op = FN_DELETE;
    else if (roll < 90) op = FN_SEARCH;
    else if (roll < 95) op = FN_CLEAR;
    else op = FUNC_W'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST));
    roll = $urandom_range(99);
    if (list_len > 0 && roll < 60) key = list_keys[$urandom_range(list_len - 1)];
    else if (roll < 80) key = KEY_W'(int'($urandom_range(3)) - 2);  // small pool -> duplicates
    else key = $urandom;
    if (op == FN_INSERT && $urandom_range(99) < 80) pos = POS_W'($urandom_range(list_len));
    else pos = POS_W'($urandom_range(31));
  endtask

  // Drive one request until the transaction completes, then record its expected result
  task automatic send_req(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] key, logic [POS_W-1:0] pos,
                          logic typed, list_result_t want);
    list_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, pos, key};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predicted = list_apply(op, key, pos);
    pending_results.push_back(typed ? want : predicted);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random back-pressure and in-order comparison
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[1:0]);
        got.index  = m_tdata[5:2];
        got.count  = m_tdata[10:6];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("index", want.index, got.index);
          check_field("count", want.count, got.count);
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side means a hang
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling on either side
    for (int r = 0; r < N_DIRECTED; r++) begin
      for (int i = 0; i < DIRECTED[r].reps; i++) begin
        send_req(DIRECTED[r].op, DIRECTED[r].key + KEY_W'(i), DIRECTED[r].pos,
                 DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // Random phases: free flow, sparse sender, slow receiver, light idling on both.
    // Each phase starts with the sender holding off until the DUT has drained.
    for (int p = 0; p < N_PHASES; p++) begin
      s_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_random_req(op, key, pos);
        send_req(op, key, pos, 1'b0, NO_TYPED);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
